// ----- src/fts_pkg.sv -----
// Package for the film transport sequencer: payload types, register map and constants.
`default_nettype none
package fts_pkg;

   localparam int unsigned FTS_COUNT_WIDTH = 16;
   localparam int unsigned ALERT_WIDTH     = 17;
   localparam int unsigned CSR_IDX_WIDTH   = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_FAST_TICK_PERIOD      = 3'd0,
      CSR_SLOW_TICK_PERIOD      = 3'd1,
      CSR_FRAME_COUNT_THRESHOLD = 3'd2,
      CSR_STALL_LIMIT           = 3'd3,
      CSR_ALERT_ON_TIME         = 3'd4,
      CSR_ALERT_OFF_TIME        = 3'd5,
      CSR_RECOVER_DELAY         = 3'd6
   } csr_index_type;

   localparam logic [15:0] FAST_TICK_PERIOD_RST      = 16'(84 * 4);
   localparam logic [15:0] SLOW_TICK_PERIOD_RST      = 16'(220 * 4);
   localparam logic [15:0] FRAME_COUNT_THRESHOLD_RST = 16'd1800;
   localparam logic [15:0] STALL_LIMIT_RST           = 16'd30000;
   localparam logic [14:0] ALERT_ON_TIME_RST         = 15'd15000;
   localparam logic [14:0] ALERT_OFF_TIME_RST        = 15'd18000;
   localparam logic [15:0] RECOVER_DELAY_RST         = 16'd500;

   // position values at which the outputs change
   localparam int unsigned POS_TAKEUP_ON       = 100;
   localparam int unsigned POS_FAST_TAKEUP_OFF = 750;
   localparam int unsigned POS_SLOW_CUT_EARLY  = 300;
   localparam int unsigned POS_SLOW_CUT_LATE   = 500;
   localparam int unsigned POS_FAST_TRIG_ON    = 4500;
   localparam int unsigned POS_FAST_TRIG_OFF   = 4550;
   localparam int unsigned POS_SLOW_TRIG_ON0   = 4500;
   localparam int unsigned POS_SLOW_TRIG_ON1   = 5800;
   localparam int unsigned POS_SLOW_TRIG_ON2   = 7100;
   localparam int unsigned POS_SLOW_TRIG_ON3   = 8400;
   localparam int unsigned SLOW_TRIG_LEN       = 8;
   localparam int unsigned STALL_LATCH_MARGIN  = 100;

   typedef struct packed {
      logic speed_fast;
      logic frame_sync;
      logic run_on;
      logic rewind_on;
      logic capstan_activity;
   } fts_req_type;

   typedef struct packed {
      logic        step_clock;
      logic        takeup_on;
      logic        stepper_on;
      logic        capstan_on;
      logic        camera_trigger;
      logic [15:0] tick_period;
      logic [15:0] frames_counted;
   } fts_rsp_type;

   typedef struct packed {
      logic [15:0] fast_tick_period;
      logic [15:0] slow_tick_period;
      logic [15:0] frame_count_threshold;
      logic [15:0] stall_limit;
      logic [14:0] alert_on_time;
      logic [14:0] alert_off_time;
      logic [15:0] recover_delay;
   } fts_cfg_type;

endpackage
`default_nettype wire

// ----- src/fts_csr.sv -----
// Configuration register file of the film transport sequencer.
`default_nettype none
module fts_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_we,
   input  wire logic [fts_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  wire logic [fts_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata,
   output fts_pkg::fts_cfg_type                      cfg
);
   import fts_pkg::*;

   fts_cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FAST_TICK_PERIOD:      cfg_in.fast_tick_period      = csr_wdata;
            CSR_SLOW_TICK_PERIOD:      cfg_in.slow_tick_period      = csr_wdata;
            CSR_FRAME_COUNT_THRESHOLD: cfg_in.frame_count_threshold = csr_wdata;
            CSR_STALL_LIMIT:           cfg_in.stall_limit           = csr_wdata;
            CSR_ALERT_ON_TIME:         cfg_in.alert_on_time         = csr_wdata[14:0];
            CSR_ALERT_OFF_TIME:        cfg_in.alert_off_time        = csr_wdata[14:0];
            CSR_RECOVER_DELAY:         cfg_in.recover_delay         = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_tick_period      <= FAST_TICK_PERIOD_RST;
         cfg_ff.slow_tick_period      <= SLOW_TICK_PERIOD_RST;
         cfg_ff.frame_count_threshold <= FRAME_COUNT_THRESHOLD_RST;
         cfg_ff.stall_limit           <= STALL_LIMIT_RST;
         cfg_ff.alert_on_time         <= ALERT_ON_TIME_RST;
         cfg_ff.alert_off_time        <= ALERT_OFF_TIME_RST;
         cfg_ff.recover_delay         <= RECOVER_DELAY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ----- src/fts_core.sv -----
// Tick state and next-state logic of the film transport sequencer.
`default_nettype none
module fts_core #(
   parameter int unsigned COUNT_WIDTH = fts_pkg::FTS_COUNT_WIDTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step,
   input  wire fts_pkg::fts_req_type item,
   input  wire fts_pkg::fts_cfg_type cfg,
   output fts_pkg::fts_rsp_type      rsp
);
   import fts_pkg::*;

   localparam logic [31:0] CNT_MAX = 32'((64'(1) << COUNT_WIDTH) - 64'(1));
   localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

   logic step_ff, step_in;
   logic takeup_ff, takeup_in;
   logic stepper_ff, stepper_in;
   logic capstan_ff, capstan_in;
   logic trigger_ff, trigger_in;
   logic started_ff, started_in;
   logic sync_seen_ff, sync_seen_in;
   logic act_seen_ff, act_seen_in;
   logic hold_ff, hold_in;
   logic [COUNT_WIDTH-1:0] pos_ff, pos_in;
   logic [COUNT_WIDTH-1:0] frame_ff, frame_in;
   logic [COUNT_WIDTH-1:0] stall_ff, stall_in;
   logic [COUNT_WIDTH-1:0] recover_ff, recover_in;
   logic [ALERT_WIDTH-1:0] alert_ff, alert_in;

   logic [31:0] pos32;
   logic        many;
   logic [31:0] latch32;
   logic [ALERT_WIDTH:0] alert_next;
   logic [31:0] frame32;

   assign pos32   = 32'(pos_ff);
   assign many    = 32'(frame_ff) > 32'(cfg.frame_count_threshold);
   assign latch32 = 32'(cfg.stall_limit) + 32'(STALL_LATCH_MARGIN);

   always_comb begin
      step_in      = !step_ff;
      takeup_in    = takeup_ff;
      stepper_in   = stepper_ff;
      capstan_in   = capstan_ff;
      trigger_in   = trigger_ff;
      started_in   = started_ff;
      sync_seen_in = sync_seen_ff;
      act_seen_in  = act_seen_ff;
      hold_in      = hold_ff;
      pos_in       = pos_ff;
      frame_in     = frame_ff;
      stall_in     = stall_ff;
      recover_in   = recover_ff;
      alert_in     = alert_ff;
      alert_next   = '0;

      if (item.speed_fast) begin
         if (pos32 == POS_TAKEUP_ON)       takeup_in  = 1'b1;
         if (pos32 == POS_FAST_TAKEUP_OFF) takeup_in  = 1'b0;
         if (pos32 == POS_FAST_TRIG_ON)    trigger_in = 1'b1;
         if (pos32 == POS_FAST_TRIG_OFF)   trigger_in = 1'b0;
      end else begin
         if (pos32 == POS_TAKEUP_ON) takeup_in = 1'b1;
         if (pos32 == POS_SLOW_CUT_EARLY && many) takeup_in = 1'b0;
         if (pos32 == POS_SLOW_CUT_LATE && !many) takeup_in = 1'b0;
         if (pos32 == POS_SLOW_TRIG_ON0 || pos32 == POS_SLOW_TRIG_ON1 ||
             pos32 == POS_SLOW_TRIG_ON2 || pos32 == POS_SLOW_TRIG_ON3)
            trigger_in = 1'b1;
         if (pos32 == POS_SLOW_TRIG_ON0 + SLOW_TRIG_LEN ||
             pos32 == POS_SLOW_TRIG_ON1 + SLOW_TRIG_LEN ||
             pos32 == POS_SLOW_TRIG_ON2 + SLOW_TRIG_LEN ||
             pos32 == POS_SLOW_TRIG_ON3 + SLOW_TRIG_LEN)
            trigger_in = 1'b0;
      end

      if (item.frame_sync && item.run_on) begin
         if (!sync_seen_ff) begin
            frame_in     = frame_ff + CNT_ONE;
            sync_seen_in = 1'b1;
         end
      end else begin
         sync_seen_in = 1'b0;
      end

      if (item.rewind_on) begin
         priority if (item.capstan_activity && !act_seen_ff) begin
            stall_in    = '0;
            act_seen_in = 1'b1;
         end else if (!item.capstan_activity && act_seen_ff) begin
            stall_in    = '0;
            act_seen_in = 1'b0;
         end else begin
            stall_in = stall_ff + CNT_ONE;
         end

         if (32'(stall_in) > 32'(cfg.stall_limit)) begin
            stepper_in = 1'b0;
            hold_in    = 1'b1;
            stall_in   = (latch32 > CNT_MAX) ? CNT_MAX[COUNT_WIDTH-1:0]
                                             : latch32[COUNT_WIDTH-1:0];
            alert_next = (ALERT_WIDTH+1)'(alert_ff) + (ALERT_WIDTH+1)'(1);
            if (alert_next[ALERT_WIDTH:2] == 16'(cfg.alert_on_time)) capstan_in = 1'b1;
            if (alert_next[ALERT_WIDTH:2] > 16'(cfg.alert_off_time)) begin
               capstan_in = 1'b0;
               alert_next = '0;
            end
            alert_in = alert_next[ALERT_WIDTH-1:0];
         end else begin
            recover_in = recover_ff + CNT_ONE;
            if (32'(recover_in) > 32'(cfg.recover_delay)) begin
               recover_in = '0;
               capstan_in = 1'b0;
               hold_in    = 1'b0;
               alert_in   = '0;
            end
         end
      end

      if (item.frame_sync) begin
         pos_in     = '0;
         started_in = 1'b1;
      end else if (started_ff) begin
         pos_in = pos_ff + CNT_ONE;
      end

      if (item.run_on) begin
         if (!hold_in) stepper_in = 1'b1;
      end else begin
         stepper_in = 1'b0;
         pos_in     = '0;
         started_in = 1'b0;
         stall_in   = '0;
         recover_in = '0;
         alert_in   = '0;
         takeup_in  = item.rewind_on;
         capstan_in = 1'b0;
         hold_in    = 1'b0;
      end
   end

   assign frame32 = 32'(frame_in);

   always_comb begin
      rsp.step_clock     = step_in;
      rsp.takeup_on      = takeup_in;
      rsp.stepper_on     = stepper_in;
      rsp.capstan_on     = capstan_in;
      rsp.camera_trigger = trigger_in;
      rsp.tick_period    = item.speed_fast ? cfg.fast_tick_period : cfg.slow_tick_period;
      rsp.frames_counted = frame32[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 1'b0;
         takeup_ff    <= 1'b0;
         stepper_ff   <= 1'b1;
         capstan_ff   <= 1'b0;
         trigger_ff   <= 1'b0;
         started_ff   <= 1'b0;
         sync_seen_ff <= 1'b0;
         act_seen_ff  <= 1'b1;
         hold_ff      <= 1'b0;
         pos_ff       <= '0;
         frame_ff     <= '0;
         stall_ff     <= '0;
         recover_ff   <= '0;
         alert_ff     <= '0;
      end else if (step) begin
         step_ff      <= step_in;
         takeup_ff    <= takeup_in;
         stepper_ff   <= stepper_in;
         capstan_ff   <= capstan_in;
         trigger_ff   <= trigger_in;
         started_ff   <= started_in;
         sync_seen_ff <= sync_seen_in;
         act_seen_ff  <= act_seen_in;
         hold_ff      <= hold_in;
         pos_ff       <= pos_in;
         frame_ff     <= frame_in;
         stall_ff     <= stall_in;
         recover_ff   <= recover_in;
         alert_ff     <= alert_in;
      end
   end

   a_step_toggles: assert property (@(posedge clock) disable iff (reset)
      step |=> step_ff != $past(step_ff))
      else $error("step clock did not toggle on a tick");

   a_run_off_clears: assert property (@(posedge clock) disable iff (reset)
      step && !item.run_on |=> pos_ff == '0 && !hold_ff && !stepper_ff && alert_ff == '0)
      else $error("run off did not clear counters");

   a_hold_stepper_off: assert property (@(posedge clock) disable iff (reset)
      hold_ff |-> !stepper_ff)
      else $error("stepper on during stall hold");

   a_alert_only_in_hold: assert property (@(posedge clock) disable iff (reset)
      (capstan_ff || alert_ff != '0) |-> hold_ff)
      else $error("alert running without stall hold");

endmodule
`default_nettype wire

// ----- src/film_transport_sequencer.sv -----
// Film transport sequencer top level: tick input register, state core and result register.
//
// One req beat is one timer tick carrying the sampled switch and sensor levels;
// one rsp beat comes back for every req beat, in order, carrying the output
// levels after that tick, the timer period for the next tick and the frame count.
// Registers are written through the csr port (write enable, index, data); the user
// must write them only while no tick is in flight, which the block does not enforce.
// A tick accepted into the tick register enters the result register when it advances,
// and its rsp beat is then offered from the result register.
// Throughput: one tick per cycle while rsp_stall is low; the state update is a single
// registered pass from the tick register into the result register.
// Reset (synchronous, active high) empties both stages and loads the register
// defaults and the initial transport state; the block is ready the next cycle.
// While rsp_stall is high the result beat holds, one more tick is taken into the
// input register, and req_stall then rises until the result is taken.
`default_nettype none
module film_transport_sequencer #(
   parameter int unsigned COUNT_WIDTH = fts_pkg::FTS_COUNT_WIDTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire fts_pkg::fts_req_type                 req_item,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output fts_pkg::fts_rsp_type                      rsp_item,
   input  wire logic                                 csr_we,
   input  wire logic [fts_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  wire logic [fts_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import fts_pkg::*;

   fts_cfg_type cfg;
   fts_rsp_type core_rsp;

   logic        s1_valid_ff, s1_valid_in;
   fts_req_type s1_item_ff, s1_item_in;
   logic        out_valid_ff, out_valid_in;
   fts_rsp_type out_item_ff, out_item_in;
   logic        s1_adv;
   logic        req_acc;

   assign s1_adv    = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_acc   = req_valid && !req_stall;

   always_comb begin
      s1_valid_in  = req_acc || (s1_valid_ff && !s1_adv);
      s1_item_in   = req_acc ? req_item : s1_item_ff;
      out_valid_in = s1_adv || (out_valid_ff && rsp_stall);
      out_item_in  = s1_adv ? core_rsp : out_item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      out_item_ff <= out_item_in;
   end

   fts_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fts_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .step  (s1_adv),
      .item  (s1_item_ff),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule
`default_nettype wire
